// ----- design/jsu_pkg.sv -----
// Shared types, codes and helpers for the JSON string unescape unit.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // Result queue sizing
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

    // Input beat kind
    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    // Result status
    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    // Parser mode
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_BODY = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX0 = 3'd3,
        MODE_HEX1 = 3'd4,
        MODE_HEX2 = 3'd5,
        MODE_HEX3 = 3'd6
    } mode_t;

    // Character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CTL_BS    = 8'h08;
    localparam logic [7:0] CTL_FF    = 8'h0c;
    localparam logic [7:0] CTL_LF    = 8'h0a;
    localparam logic [7:0] CTL_CR    = 8'h0d;
    localparam logic [7:0] CTL_TAB   = 8'h09;

    // One result beat
    typedef struct packed {
        logic [7:0] data;
        status_t    status;
        logic       last;
    } result_t;

    // Everything one input beat produces
    typedef struct packed {
        logic [RCNT_W-1:0]            count;
        result_t [MAX_RESULTS-1:0]    item;
    } decode_t;

    // Hex digit of either case: {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/jsu_decoder.sv -----
// Parser state and combinational decode of one input beat into up to three results.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decoder
    import jsu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_fire,
    input  wire logic [1:0] in_kind,
    input  wire logic [7:0] in_byte,
    output decode_t         dec
);

    mode_t       mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;

    logic [4:0]  hex;
    logic [15:0] cp;

    assign hex = hex_digit(in_byte);
    assign cp  = {acc_reg[11:0], hex[3:0]};

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= 16'd0;
        end else begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

    // Decode
    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        dec       = '0;
        if (in_fire) begin
            unique case (in_kind)
                KIND_START: begin
                    acc_next = 16'd0;
                    if (in_byte == CH_QUOTE) begin
                        mode_next = MODE_BODY;
                    end else begin
                        mode_next             = MODE_IDLE;
                        dec.count             = RCNT_W'(1);
                        dec.item[0].status    = ST_ERR;
                    end
                end
                KIND_BYTE: begin
                    unique case (mode_reg)
                        MODE_BODY: begin
                            if (in_byte == CH_QUOTE) begin
                                mode_next          = MODE_IDLE;
                                dec.count          = RCNT_W'(1);
                                dec.item[0].status = ST_DONE;
                            end else if (in_byte == CH_BSLASH) begin
                                mode_next = MODE_ESC;
                            end else begin
                                dec.count          = RCNT_W'(1);
                                dec.item[0].data   = in_byte;
                                dec.item[0].status = ST_DATA;
                            end
                        end
                        MODE_ESC: begin
                            mode_next          = MODE_BODY;
                            dec.count          = RCNT_W'(1);
                            dec.item[0].status = ST_DATA;
                            unique case (in_byte)
                                CH_QUOTE:  dec.item[0].data = CH_QUOTE;
                                CH_BSLASH: dec.item[0].data = CH_BSLASH;
                                CH_SLASH:  dec.item[0].data = CH_SLASH;
                                CH_B:      dec.item[0].data = CTL_BS;
                                CH_F:      dec.item[0].data = CTL_FF;
                                CH_N:      dec.item[0].data = CTL_LF;
                                CH_R:      dec.item[0].data = CTL_CR;
                                CH_T:      dec.item[0].data = CTL_TAB;
                                CH_U: begin
                                    acc_next  = 16'd0;
                                    mode_next = MODE_HEX0;
                                    dec.count = RCNT_W'(0);
                                end
                                default: begin
                                    acc_next           = 16'd0;
                                    mode_next          = MODE_IDLE;
                                    dec.item[0].status = ST_ERR;
                                end
                            endcase
                        end
                        MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                            if (!hex[4]) begin
                                acc_next           = 16'd0;
                                mode_next          = MODE_IDLE;
                                dec.count          = RCNT_W'(1);
                                dec.item[0].status = ST_ERR;
                            end else if (mode_reg != MODE_HEX3) begin
                                acc_next  = cp;
                                mode_next = mode_t'(mode_reg + 3'd1);
                            end else begin
                                // Fourth digit: emit the code point as UTF-8
                                acc_next  = cp;
                                mode_next = MODE_BODY;
                                if (cp[15:7] == 9'd0) begin
                                    dec.count        = RCNT_W'(1);
                                    dec.item[0].data = cp[7:0];
                                end else if (cp[15:11] == 5'd0) begin
                                    dec.count        = RCNT_W'(2);
                                    dec.item[0].data = {3'b110, cp[10:6]};
                                    dec.item[1].data = {2'b10, cp[5:0]};
                                end else begin
                                    dec.count        = RCNT_W'(3);
                                    dec.item[0].data = {4'b1110, cp[15:12]};
                                    dec.item[1].data = {2'b10, cp[11:6]};
                                    dec.item[2].data = {2'b10, cp[5:0]};
                                end
                            end
                        end
                        default: ; // idle: byte ignored
                    endcase
                end
                KIND_END: begin
                    if (mode_reg != MODE_IDLE) begin
                        acc_next           = 16'd0;
                        mode_next          = MODE_IDLE;
                        dec.count          = RCNT_W'(1);
                        dec.item[0].status = ST_ERR;
                    end
                end
                default: ; // unused kind: ignored
            endcase
            // Flag the final result of this beat
            for (int i = 0; i < MAX_RESULTS; i++) begin
                dec.item[i].last = (dec.count == RCNT_W'(i + 1));
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/jsu_result_queue.sv -----
// Register queue: takes up to three results per cycle, sends one beat per ready cycle.
`timescale 1ns / 1ps
`default_nettype none

module jsu_result_queue
    import jsu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire decode_t    dec,
    output logic            space_ok,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic [1:0]      m_status,
    output logic            m_last
);

    result_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               pop;
    result_t            head;

    assign pop      = m_valid && m_ready;
    assign space_ok = count_reg <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS);

    // Occupancy
    always_comb begin
        count_next = count_reg + QCNT_W'(dec.count) - QCNT_W'(pop);
    end

    // Pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(dec.count);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (RCNT_W'(i) < dec.count) begin
                mem[wr_ptr_reg + QPTR_W'(i)] <= dec.item[i];
            end
        end
    end

    // Head beat
    assign head       = mem[rd_ptr_reg];
    assign m_valid    = count_reg != '0;
    assign m_out_byte = head.data;
    assign m_status   = head.status;
    assign m_last     = head.last;

endmodule

`default_nettype wire

// ----- design/json_string_unescape_unit.sv -----
// Top level of the JSON string unescape unit: decoder plus result queue.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | s_kind[1:0], s_in_byte[7:0]
//  m_      | out | m_valid / m_ready  | m_out_byte[7:0], m_status[1:0], m_last
//
// While s_ready is high one input beat is taken per cycle; its results land in the queue
// on the same edge and the first can leave on the next cycle. A \u escape gives up to
// three result beats from its last hex digit; the queue sends one per ready cycle.
// s_ready is high while the eight-entry queue has room for three more results.
// aresetn clears the parser mode and empties the queue; m_ready low only fills the queue.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_unit
    import jsu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_kind,
    input  wire logic [7:0] s_in_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic [1:0]      m_status,
    output logic            m_last
);

    decode_t dec;
    logic    space_ok;

    assign s_ready = space_ok;

    jsu_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (s_valid && s_ready),
        .in_kind (s_kind),
        .in_byte (s_in_byte),
        .dec     (dec)
    );

    jsu_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dec        (dec),
        .space_ok   (space_ok),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_status   (m_status),
        .m_last     (m_last)
    );

endmodule

`default_nettype wire

// ----- design/jsu_checker.sv -----
// Port-level checks for the JSON string unescape unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module jsu_checker
    import jsu_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic [1:0] m_status,
    input wire logic       m_last
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_status)
                                && $stable(m_last))
        else $error("result beat changed while stalled");

    // Completion and error beats carry a zero byte
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_DONE || m_status == ST_ERR) |-> m_out_byte == 8'd0)
        else $error("non-data beat with nonzero byte");

    // Completion and error are always the final beat of their input
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_DONE || m_status == ST_ERR) |-> m_last)
        else $error("completion or error beat without last");

    // No result beats right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Queue never refuses input while no results are pending
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty queue");

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_status   (m_status),
    .m_last     (m_last)
);

`default_nettype wire
